### sv/irpd_pkg.sv
`timescale 1ns / 1ps
// irpd_pkg: shared types and constants for the ir pulse distance transmitter
// no dependencies

package irpd_pkg;

	localparam int DUR_W   = 16;
	localparam int BITC_W  = 6;
	localparam int MASK_W  = 6;
	localparam int CODE_W  = 32;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_KINDS = 6;

	// segment kinds, also the bit order of the mark mask
	typedef enum logic [2:0] {
		KIND_START1 = 3'd0,
		KIND_START2 = 3'd1,
		KIND_ONE1   = 3'd2,
		KIND_ONE2   = 3'd3,
		KIND_ZERO1  = 3'd4,
		KIND_ZERO2  = 3'd5
	} seg_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIT_COUNT    = 3'd0,
		REG_START_FIRST  = 3'd1,
		REG_START_SECOND = 3'd2,
		REG_ONE_FIRST    = 3'd3,
		REG_ONE_SECOND   = 3'd4,
		REG_ZERO_FIRST   = 3'd5,
		REG_ZERO_SECOND  = 3'd6,
		REG_MARK_MASK    = 3'd7
	} reg_idx_t;

	localparam logic [BITC_W-1:0] RST_BIT_COUNT    = 6'd32;
	localparam logic [DUR_W-1:0]  RST_START_FIRST  = 16'd9000;
	localparam logic [DUR_W-1:0]  RST_START_SECOND = 16'd4500;
	localparam logic [DUR_W-1:0]  RST_ONE_FIRST    = 16'd560;
	localparam logic [DUR_W-1:0]  RST_ONE_SECOND   = 16'd1690;
	localparam logic [DUR_W-1:0]  RST_ZERO_FIRST   = 16'd560;
	localparam logic [DUR_W-1:0]  RST_ZERO_SECOND  = 16'd560;
	localparam logic [MASK_W-1:0] RST_MARK_MASK    = 6'd21;

endpackage

### sv/ir_pulse_distance_transmitter.sv
`timescale 1ns / 1ps
// ir_pulse_distance_transmitter: tick driven infrared pulse distance sender
// depends on irpd_pkg
//
// channel   dir  signals                       content
// s_*       in   tvalid tready tuser tdata     tuser: op; tdata: code
// m_*       out  tvalid tready tlast tdata     tlast: frame_done; tdata: pin, busy_res
// cfg_*     in   we index data                 register writes, no read-back
//
// one item per cycle sustained while the master side takes results: an input register
// feeds one pass of segment logic (two leading-one searches over the segment list)
// into the output register. each item is held in the input register and then in
// the output register before its result is offered.
// arst_n clears frame state and loads the register defaults.
// a stall on the master side holds the result; the input register keeps taking
// items until both stages are full.

module ir_pulse_distance_transmitter
	import irpd_pkg::*;
#(
	parameter int CARRIER_HALF_US = 12,
	parameter int MAX_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic                 s_tuser,     // [0] op
	input  logic [CODE_W-1:0]    s_tdata,     // [31:0] code
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic                 m_tlast,     // frame_done
	output logic [7:0]           m_tdata,     // [0] pin, [1] busy_res, [7:2] zero
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int NSEG   = 2 + 2 * MAX_BITS;
	localparam int SIDX_W = $clog2(NSEG);
	localparam int NB_W   = $clog2(MAX_BITS + 1);
	localparam int PER    = 2 * CARRIER_HALF_US;
	localparam int PH_W   = $clog2(PER);
	localparam int EL_W   = DUR_W + 1;

	// configuration registers
	logic [BITC_W-1:0] bit_count_q;
	logic [DUR_W-1:0]  kind_dur_q [NUM_KINDS];
	logic [MASK_W-1:0] mark_mask_q;

	// frame state
	logic              busy_q;
	logic [MAX_BITS-1:0] code_q;
	logic [SIDX_W-1:0] seg_q;
	logic [EL_W-1:0]   elapsed_q;
	logic [PH_W-1:0]   phase_q;

	// input and output stages
	logic              valid_s1;
	logic              op_s1;
	logic [CODE_W-1:0] code_s1;
	logic              out_valid_q;
	logic              pin_q, busy_res_q, done_q;

	logic              adv;

	// next-state signals
	logic [MAX_BITS-1:0] code_sel;
	logic [SIDX_W-1:0]   from_sel;
	logic [NB_W-1:0]     nb;
	logic [MAX_BITS-1:0] shifted;
	logic [NSEG-1:0]     nzv;
	seg_kind_t           kindv [NSEG];
	logic [SIDX_W:0]     srch_a, srch_b;
	logic                found_a, found_b;
	logic [SIDX_W-1:0]   idx_a, idx_b;
	seg_kind_t           kind_a;
	logic [DUR_W-1:0]    dur_a;
	logic                mark_a;
	logic [EL_W-1:0]     el_inc;
	logic [PH_W:0]       ph_inc;
	logic [PH_W-1:0]     ph_wrap;
	logic                finished;

	logic                busy_d, pin_d, done_d, load_code;
	logic [SIDX_W-1:0]   seg_d;
	logic [EL_W-1:0]     el_d;
	logic [PH_W-1:0]     ph_d;

	// first nonzero-length segment at or after (or strictly after) a position
	function automatic logic [SIDX_W:0] first_set(input logic [NSEG-1:0] v,
			input logic [SIDX_W-1:0] from, input logic strict);
		logic [SIDX_W:0] res;
		res = '0;
		for (int j = NSEG - 1; j >= 0; j--) begin
			if (v[j] && ((SIDX_W'(j) > from) || (!strict && SIDX_W'(j) == from)))
				res = {1'b1, SIDX_W'(j)};
		end
		return res;
	endfunction

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tlast  = done_q;
	assign m_tdata  = {6'd0, busy_res_q, pin_q};

	// bit kinds come from the stored code, or from the new code on a start
	assign load_code = op_s1 && !busy_q && (code_s1 != '0);
	assign code_sel  = op_s1 ? code_s1[MAX_BITS-1:0] : code_q;
	assign from_sel  = op_s1 ? '0 : seg_q;
	assign nb        = (bit_count_q > BITC_W'(MAX_BITS)) ? NB_W'(MAX_BITS)
	                                                    : NB_W'(bit_count_q);
	// the top used bit of the code (bit nb-1) lands on the top bit
	assign shifted   = code_sel << (NB_W'(MAX_BITS) - nb);

	always_comb begin
		for (int j = 0; j < NSEG; j++) begin
			if (j == 0) begin
				kindv[j] = KIND_START1;
				nzv[j]   = (kind_dur_q[KIND_START1] != '0);
			end else if (j == 1) begin
				kindv[j] = KIND_START2;
				nzv[j]   = (kind_dur_q[KIND_START2] != '0);
			end else begin
				if (shifted[MAX_BITS - 1 - ((j - 2) >> 1)])
					kindv[j] = (j % 2 == 1) ? KIND_ONE2 : KIND_ONE1;
				else
					kindv[j] = (j % 2 == 1) ? KIND_ZERO2 : KIND_ZERO1;
				nzv[j] = (NB_W'((j - 2) >> 1) < nb) && (kind_dur_q[kindv[j]] != '0);
			end
		end
	end

	assign srch_a  = first_set(nzv, from_sel, 1'b0);
	assign found_a = srch_a[SIDX_W];
	assign idx_a   = srch_a[SIDX_W-1:0];
	assign srch_b  = first_set(nzv, idx_a, 1'b1);
	assign found_b = srch_b[SIDX_W];
	assign idx_b   = srch_b[SIDX_W-1:0];

	assign kind_a  = kindv[idx_a];
	assign dur_a   = kind_dur_q[kind_a];
	assign mark_a  = mark_mask_q[kind_a];
	assign el_inc  = elapsed_q + EL_W'(1);
	assign ph_inc  = {1'b0, phase_q} + (PH_W + 1)'(1);
	assign ph_wrap = (ph_inc >= (PH_W + 1)'(PER)) ? '0 : ph_inc[PH_W-1:0];
	assign finished = (el_inc >= EL_W'(dur_a)) && (!mark_a || ph_wrap == '0);

	always_comb begin
		busy_d = busy_q;
		pin_d  = 1'b0;
		done_d = 1'b0;
		seg_d  = seg_q;
		el_d   = elapsed_q;
		ph_d   = phase_q;
		if (op_s1) begin
			if (load_code) begin
				el_d = '0;
				ph_d = '0;
				if (found_a) begin
					busy_d = 1'b1;
					seg_d  = idx_a;
				end else begin
					busy_d = 1'b0;
					seg_d  = '0;
					done_d = 1'b1;
				end
			end
		end else if (busy_q) begin
			if (!found_a) begin
				busy_d = 1'b0;
				done_d = 1'b1;
				seg_d  = '0;
				el_d   = '0;
				ph_d   = '0;
			end else begin
				// elapsed time carries over a skipped segment
				pin_d = mark_a && (phase_q < PH_W'(CARRIER_HALF_US));
				if (finished) begin
					el_d = '0;
					ph_d = '0;
					if (found_b) begin
						seg_d = idx_b;
					end else begin
						busy_d = 1'b0;
						done_d = 1'b1;
						seg_d  = '0;
					end
				end else begin
					seg_d = idx_a;
					el_d  = el_inc;
					ph_d  = mark_a ? ph_wrap : phase_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q   <= RST_BIT_COUNT;
			kind_dur_q[KIND_START1] <= RST_START_FIRST;
			kind_dur_q[KIND_START2] <= RST_START_SECOND;
			kind_dur_q[KIND_ONE1]   <= RST_ONE_FIRST;
			kind_dur_q[KIND_ONE2]   <= RST_ONE_SECOND;
			kind_dur_q[KIND_ZERO1]  <= RST_ZERO_FIRST;
			kind_dur_q[KIND_ZERO2]  <= RST_ZERO_SECOND;
			mark_mask_q   <= RST_MARK_MASK;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BIT_COUNT:    bit_count_q <= cfg_data[BITC_W-1:0];
				REG_START_FIRST:  kind_dur_q[KIND_START1] <= cfg_data;
				REG_START_SECOND: kind_dur_q[KIND_START2] <= cfg_data;
				REG_ONE_FIRST:    kind_dur_q[KIND_ONE1]   <= cfg_data;
				REG_ONE_SECOND:   kind_dur_q[KIND_ONE2]   <= cfg_data;
				REG_ZERO_FIRST:   kind_dur_q[KIND_ZERO1]  <= cfg_data;
				REG_ZERO_SECOND:  kind_dur_q[KIND_ZERO2]  <= cfg_data;
				REG_MARK_MASK:    mark_mask_q <= cfg_data[MASK_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			code_q    <= '0;
			seg_q     <= '0;
			elapsed_q <= '0;
			phase_q   <= '0;
		end else if (adv) begin
			busy_q    <= busy_d;
			seg_q     <= seg_d;
			elapsed_q <= el_d;
			phase_q   <= ph_d;
			if (load_code)
				code_q <= code_s1[MAX_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			code_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pin_q      <= pin_d;
			busy_res_q <= busy_d;
			done_q     <= done_d;
		end
	end

endmodule

### test/tb_ir_pulse_distance_transmitter.sv
`timescale 1ns / 1ps
// tb_ir_pulse_distance_transmitter: self-checking bench for the ir pulse distance sender
// depends on irpd_pkg and ir_pulse_distance_transmitter; tick/start items are predicted
// in-bench and every output transfer is compared against the predicted pin/busy/done trace

module tb_ir_pulse_distance_transmitter;
	import irpd_pkg::*;

	localparam int CARRIER_HALF_US = 12;
	localparam int MAX_BITS        = 32;
	localparam int ITEM_TARGET     = 1650;
	localparam int STALL_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 8;
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef struct packed {
		logic              op;
		logic [CODE_W-1:0] code;
	} tx_item_t;

	typedef struct packed {
		logic pin;
		logic busy;
		logic done;
	} trace_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic                 s_tuser;
	logic [CODE_W-1:0]    s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic                 m_tlast;
	logic [7:0]           m_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	tx_item_t tx_items_q[$];
	trace_t   pin_trace_q[$];

	// register shadow
	logic [BITC_W-1:0] bits_reg;
	logic [MASK_W-1:0] mask_reg;
	logic [DUR_W-1:0]  dur_reg [NUM_KINDS];

	// frame state
	logic              tx_busy;
	logic [CODE_W-1:0] code_sh;
	int unsigned       seg_no;
	int unsigned       elapsed;
	int unsigned       phase;

	logic in_taken;
	logic calm;
	int   fail_count;
	int   item_count;
	int   frames_done;
	int   results_seen;
	int   idle_cycles;

	ir_pulse_distance_transmitter #(
		.CARRIER_HALF_US(CARRIER_HALF_US),
		.MAX_BITS(MAX_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tlast(m_tlast),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int unsigned eff_bits();
		return (bits_reg > MAX_BITS) ? MAX_BITS : int'(bits_reg);
	endfunction

	function automatic seg_kind_t kind_of(input int unsigned s);
		int unsigned nb;
		int unsigned i;
		nb = eff_bits();
		if (s == 0) return KIND_START1;
		if (s == 1) return KIND_START2;
		i = (s - 2) >> 1;
		if (i < nb && code_sh[nb - 1 - i])
			return s[0] ? KIND_ONE2 : KIND_ONE1;
		return s[0] ? KIND_ZERO2 : KIND_ZERO1;
	endfunction

	// step over zero-length segments, close the frame when none are left
	function automatic logic skip_empty();
		int unsigned total;
		total = 2 + 2 * eff_bits();
		while (seg_no < total && dur_reg[kind_of(seg_no)] == 0)
			seg_no++;
		if (seg_no >= total) begin
			tx_busy = 1'b0;
			seg_no = 0;
			elapsed = 0;
			phase = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic trace_t advance_frame(input logic op, input logic [CODE_W-1:0] code);
		trace_t    r;
		seg_kind_t k;
		logic      finished;
		r = '0;
		if (op == OP_START) begin
			if (!tx_busy && code != 0) begin
				code_sh = code;
				seg_no = 0;
				elapsed = 0;
				phase = 0;
				tx_busy = 1'b1;
				if (skip_empty()) r.done = 1'b1;
			end
		end else if (tx_busy) begin
			if (skip_empty()) begin
				r.done = 1'b1;
			end else begin
				k = kind_of(seg_no);
				elapsed++;
				if (mask_reg[k]) begin
					r.pin = (phase < CARRIER_HALF_US);
					phase++;
					if (phase >= 2 * CARRIER_HALF_US) phase = 0;
					finished = (elapsed >= dur_reg[k]) && (phase == 0);
				end else begin
					finished = (elapsed >= dur_reg[k]);
				end
				if (finished) begin
					seg_no++;
					elapsed = 0;
					phase = 0;
					if (skip_empty()) r.done = 1'b1;
				end
			end
		end
		r.busy = tx_busy;
		return r;
	endfunction

	// ticks one segment kind takes with the current settings
	function automatic int unsigned seg_ticks(input seg_kind_t k);
		int unsigned period;
		period = 2 * CARRIER_HALF_US;
		if (dur_reg[k] == 0) return 0;
		if (mask_reg[k]) return ((int'(dur_reg[k]) + period - 1) / period) * period;
		return dur_reg[k];
	endfunction

	function automatic int unsigned frame_span(input logic [CODE_W-1:0] code);
		int unsigned t;
		int unsigned nb;
		nb = eff_bits();
		t = seg_ticks(KIND_START1) + seg_ticks(KIND_START2);
		for (int unsigned i = 0; i < nb; i++) begin
			if (code[nb - 1 - i])
				t += seg_ticks(KIND_ONE1) + seg_ticks(KIND_ONE2);
			else
				t += seg_ticks(KIND_ZERO1) + seg_ticks(KIND_ZERO2);
		end
		return t;
	endfunction

	function automatic logic [DUR_W-1:0] pick_dur();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 25) return '0;
		if (roll < 75) return DUR_W'($urandom_range(1, 30));
		return DUR_W'($urandom_range(31, 60));
	endfunction

	task automatic queue_item(input logic op, input logic [CODE_W-1:0] code);
		tx_items_q.push_back('{op: op, code: code});
		item_count++;
	endtask

	task automatic queue_ticks(input int unsigned n);
		repeat (n) queue_item(OP_TICK, $urandom);
	endtask

	task automatic queue_frame(input logic [CODE_W-1:0] code);
		queue_item(OP_START, code);
		queue_ticks(frame_span(code));
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_BIT_COUNT: bits_reg = val[BITC_W-1:0];
			REG_MARK_MASK: mask_reg = val[MASK_W-1:0];
			default: dur_reg[idx - REG_START_FIRST] = val;
		endcase
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold off until every queued item went in and every result came back
	task automatic settle();
		do @(negedge clk);
		while (tx_items_q.size() != 0 || s_tvalid || pin_trace_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// input driver
	always @(negedge clk) begin
		tx_item_t nxt;
		if (!s_tvalid || in_taken) begin
			if (tx_items_q.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
				nxt = tx_items_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= nxt.op;
				s_tdata <= nxt.code;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 31);
	end

	// prediction on input transfer, comparison on output transfer
	always @(posedge clk) begin
		trace_t want;
		in_taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			want = advance_frame(s_tuser, s_tdata);
			if (want.done) frames_done++;
			pin_trace_q.push_back(want);
		end
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (pin_trace_q.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				want = pin_trace_q.pop_front();
				if (m_tdata[0] !== want.pin) begin
					$error("pin: expected %0d, got %0d", want.pin, m_tdata[0]);
					fail_count++;
				end
				if (m_tdata[1] !== want.busy) begin
					$error("busy_res: expected %0d, got %0d", want.busy, m_tdata[1]);
					fail_count++;
				end
				if (m_tlast !== want.done) begin
					$error("frame_done: expected %0d, got %0d", want.done, m_tlast);
					fail_count++;
				end
				if (m_tdata[7:2] !== 6'd0) begin
					$error("pad: expected 0, got %0d", m_tdata[7:2]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned      span;
		int unsigned      cut;
		int unsigned      roll;
		logic [CODE_W-1:0] code;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_taken = 1'b0;
		calm = 1'b0;
		fail_count = 0;
		item_count = 0;
		frames_done = 0;
		results_seen = 0;
		idle_cycles = 0;
		bits_reg = RST_BIT_COUNT;
		mask_reg = RST_MARK_MASK;
		dur_reg[KIND_START1] = RST_START_FIRST;
		dur_reg[KIND_START2] = RST_START_SECOND;
		dur_reg[KIND_ONE1] = RST_ONE_FIRST;
		dur_reg[KIND_ONE2] = RST_ONE_SECOND;
		dur_reg[KIND_ZERO1] = RST_ZERO_FIRST;
		dur_reg[KIND_ZERO2] = RST_ZERO_SECOND;
		tx_busy = 1'b0;
		code_sh = '0;
		seg_no = 0;
		elapsed = 0;
		phase = 0;

		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// reset defaults: idle tick, zero code, full code, start while busy
		queue_item(OP_TICK, 32'hFFFF_FFFF);
		queue_item(OP_START, 32'h0);
		queue_item(OP_TICK, 32'h0);
		queue_item(OP_START, 32'hFFFF_FFFF);
		queue_ticks(30);
		queue_item(OP_START, 32'h1234_5678);
		queue_ticks(3);
		settle();

		// frame cut short mid start segment by a register write
		write_reg(REG_START_FIRST, 16'd0);
		write_reg(REG_START_SECOND, 16'd0);
		write_reg(REG_BIT_COUNT, 16'd0);
		end_writes();
		queue_ticks(2);
		settle();

		// shrink the bit count below the current segment
		write_reg(REG_BIT_COUNT, 16'd4);
		write_reg(REG_MARK_MASK, 16'd0);
		write_reg(REG_START_FIRST, 16'd2);
		write_reg(REG_START_SECOND, 16'd2);
		write_reg(REG_ONE_FIRST, 16'd2);
		write_reg(REG_ONE_SECOND, 16'd2);
		write_reg(REG_ZERO_FIRST, 16'd2);
		write_reg(REG_ZERO_SECOND, 16'd2);
		end_writes();
		queue_item(OP_START, 32'h0000_00F0);
		queue_ticks(16);
		settle();
		write_reg(REG_BIT_COUNT, 16'd1);
		end_writes();
		queue_ticks(2);
		settle();

		// every segment empty: frame ends on the start itself
		write_reg(REG_START_FIRST, 16'd0);
		write_reg(REG_START_SECOND, 16'd0);
		write_reg(REG_ONE_FIRST, 16'd0);
		write_reg(REG_ONE_SECOND, 16'd0);
		write_reg(REG_ZERO_FIRST, 16'd0);
		write_reg(REG_ZERO_SECOND, 16'd0);
		end_writes();
		queue_item(OP_START, 32'h0000_0001);
		queue_ticks(2);
		settle();

		// start pair only
		write_reg(REG_BIT_COUNT, 16'd0);
		write_reg(REG_START_FIRST, 16'd3);
		write_reg(REG_START_SECOND, 16'd2);
		write_reg(REG_MARK_MASK, 16'd1);
		end_writes();
		queue_frame(32'h8000_0000);
		queue_ticks(2);
		settle();

		// bit count above the maximum saturates, all segments are spaces
		write_reg(REG_BIT_COUNT, {10'($urandom), 6'd45});
		write_reg(REG_MARK_MASK, {10'($urandom), 6'd0});
		write_reg(REG_START_FIRST, 16'd1);
		write_reg(REG_START_SECOND, 16'd1);
		write_reg(REG_ONE_FIRST, 16'd1);
		write_reg(REG_ONE_SECOND, 16'd2);
		write_reg(REG_ZERO_FIRST, 16'd2);
		write_reg(REG_ZERO_SECOND, 16'd1);
		end_writes();
		code = $urandom | 32'h1;
		queue_frame(code);
		queue_frame(~code);
		queue_ticks(2);
		settle();

		// long mark, run at full rate on both sides
		calm <= 1'b1;
		write_reg(REG_BIT_COUNT, 16'd1);
		write_reg(REG_MARK_MASK, 16'd63);
		write_reg(REG_START_FIRST, 16'd290);
		write_reg(REG_START_SECOND, 16'd0);
		write_reg(REG_ONE_FIRST, 16'd0);
		write_reg(REG_ONE_SECOND, 16'd0);
		write_reg(REG_ZERO_FIRST, 16'd0);
		write_reg(REG_ZERO_SECOND, 16'd0);
		end_writes();
		@(negedge clk);
		queue_frame($urandom | 32'h1);
		queue_ticks(2);
		settle();
		calm <= 1'b0;
		@(negedge clk);

		// random settings, mostly complete frames with some cut-off and noise
		while (item_count < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			write_reg(REG_BIT_COUNT, {10'($urandom),
				6'((roll < 10) ? 0 : $urandom_range(1, 5))});
			write_reg(REG_START_FIRST, pick_dur());
			write_reg(REG_START_SECOND, pick_dur());
			write_reg(REG_ONE_FIRST, pick_dur());
			write_reg(REG_ONE_SECOND, pick_dur());
			write_reg(REG_ZERO_FIRST, pick_dur());
			write_reg(REG_ZERO_SECOND, pick_dur());
			write_reg(REG_MARK_MASK, 16'($urandom));
			end_writes();
			repeat ($urandom_range(3, 6)) begin
				roll = $urandom_range(0, 99);
				code = $urandom;
				if (code == 0) code = 32'h1;
				span = frame_span(code);
				if (roll < 70) begin
					queue_frame(code);
					queue_ticks($urandom_range(0, 3));
				end else if (roll < 85) begin
					cut = $urandom_range(0, span);
					queue_item(OP_START, code);
					queue_ticks(cut);
					queue_item(OP_START, $urandom);
					queue_ticks(span - cut + 1);
				end else begin
					repeat ($urandom_range(1, 6))
						queue_item(1'($urandom), ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom);
				end
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pin_trace_q.size() != 0) begin
			$error("%0d expected results never arrived", pin_trace_q.size());
			fail_count++;
		end
		$display("covered %0d items, %0d results checked, %0d frames finished",
			item_count, results_seen, frames_done);
		$display("settings swept: reset values, empty frames, saturated bit count, long mark");
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
sv/irpd_pkg.sv
sv/ir_pulse_distance_transmitter.sv
test/tb_ir_pulse_distance_transmitter.sv
